[design/u8dec_pkg.sv]
`default_nettype none

package u8dec_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  localparam logic [CpW-1:0] SubstChar = CpW'(63);

  typedef struct packed {
    logic [PendW-1:0] pending;
    logic [CpW-1:0]   partial;
  } state_t;

  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    logic           was_truncated;
    logic           final_result;
  } result_t;

endpackage

`default_nettype wire

[design/u8dec_if.sv]
`default_nettype none

interface u8dec_byte_if;
  logic                          valid;
  logic                          ready;
  logic [u8dec_pkg::ByteW-1:0]   byte_in;
  logic                          end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

interface u8dec_cp_if;
  logic                        valid;
  logic                        ready;
  logic [u8dec_pkg::CpW-1:0]   code_point;
  logic                        was_truncated;
  logic                        final_result;

  modport source (output valid, output code_point, output was_truncated,
                  output final_result, input ready);
  modport sink   (input valid, input code_point, input was_truncated,
                  input final_result, output ready);
endinterface

`default_nettype wire

[design/utf8_to_code_point_decoder_top.sv]
`default_nettype none

// channel  role    payload                                       request moved
// req_i    sink    byte_in[7:0], end_of_string                   one utf-8 byte
// rsp_o    source  code_point[20:0], was_truncated, final_result  one code point
//
// one byte per cycle unless rsp_o stalls; a result shows the cycle after its byte
// the decode step is a single pass of shift and mask logic into a result register
// reset clears the pending count, the gathered value and the result valid flag
// a stalled result holds; bytes keep flowing whenever the result register is
// empty or being drained in the same cycle

module utf8_to_code_point_decoder_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  u8dec_byte_if.sink req_i,
  u8dec_cp_if.source rsp_o
);

  u8dec_pkg::state_t  state_q;
  u8dec_pkg::state_t  state_d;
  u8dec_pkg::result_t step_res;
  u8dec_pkg::result_t res_q;
  logic               req_fire;

  assign req_i.ready = !res_q.valid || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  u8dec_step u_step (
    .state_i  (state_q),
    .byte_i   (req_i.byte_in),
    .fin_i    (req_i.end_of_string),
    .state_o  (state_d),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      res_q   <= '0;
    end else begin
      if (req_fire) begin
        state_q <= state_d;
        res_q   <= step_res;
      end else if (rsp_o.ready) begin
        res_q.valid <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = res_q.valid;
  assign rsp_o.code_point    = res_q.code_point;
  assign rsp_o.was_truncated = res_q.was_truncated;
  assign rsp_o.final_result  = res_q.final_result;

endmodule

`default_nettype wire

[design/u8dec_step.sv]
`default_nettype none

module u8dec_step (
  input  wire u8dec_pkg::state_t               state_i,
  input  wire logic [u8dec_pkg::ByteW-1:0]     byte_i,
  input  wire logic                            fin_i,
  output u8dec_pkg::state_t                    state_o,
  output u8dec_pkg::result_t                   result_o
);

  localparam logic [2:0] Lead2Pat = 3'b110;
  localparam logic [3:0] Lead3Pat = 4'b1110;
  localparam logic [4:0] Lead4Pat = 5'b11110;

  logic [u8dec_pkg::CpW-1:0]   shifted;
  logic [u8dec_pkg::PendW-1:0] pend_m1;
  logic [u8dec_pkg::PendW-1:0] need;
  logic [u8dec_pkg::CpW-1:0]   lead;
  logic                        is_lead;

  assign shifted = {state_i.partial[u8dec_pkg::CpW-7:0], byte_i[5:0]};
  assign pend_m1 = state_i.pending - u8dec_pkg::PendW'(1);

  always_comb begin
    need    = '0;
    lead    = '0;
    is_lead = 1'b0;
    if (byte_i[7:5] == Lead2Pat) begin
      need    = u8dec_pkg::PendW'(1);
      lead    = u8dec_pkg::CpW'(byte_i[4:0]);
      is_lead = 1'b1;
    end else if (byte_i[7:4] == Lead3Pat) begin
      need    = u8dec_pkg::PendW'(2);
      lead    = u8dec_pkg::CpW'(byte_i[3:0]);
      is_lead = 1'b1;
    end else if (byte_i[7:3] == Lead4Pat) begin
      need    = u8dec_pkg::PendW'(3);
      lead    = u8dec_pkg::CpW'(byte_i[2:0]);
      is_lead = 1'b1;
    end
  end

  always_comb begin
    state_o  = '0;
    result_o = '0;
    if (state_i.pending != '0) begin
      if (pend_m1 == '0) begin
        result_o.valid        = 1'b1;
        result_o.code_point   = shifted;
        result_o.final_result = fin_i;
      end else if (fin_i) begin
        result_o.valid         = 1'b1;
        result_o.code_point    = u8dec_pkg::SubstChar;
        result_o.was_truncated = 1'b1;
        result_o.final_result  = 1'b1;
      end else begin
        state_o.pending = pend_m1;
        state_o.partial = shifted;
      end
    end else if (!byte_i[7]) begin
      result_o.valid        = 1'b1;
      result_o.code_point   = u8dec_pkg::CpW'(byte_i);
      result_o.final_result = fin_i;
    end else if (is_lead) begin
      if (fin_i) begin
        result_o.valid         = 1'b1;
        result_o.code_point    = u8dec_pkg::SubstChar;
        result_o.was_truncated = 1'b1;
        result_o.final_result  = 1'b1;
      end else begin
        state_o.pending = need;
        state_o.partial = lead;
      end
    end
  end

endmodule

`default_nettype wire
